### design/sha256_pkg.sv
// shared types, constants and round functions for the sha-256 stream hasher
package sha256_pkg;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef enum logic [1:0] {
    BS_ZERO = 2'd0,
    BS_DATA = 2'd1,
    BS_PAD  = 2'd2,
    BS_LEN  = 2'd3
  } byte_src_t;

  // controller to datapath
  typedef struct packed {
    logic      wr_byte;     // write a byte into the block buffer
    byte_src_t src;         // what the written byte is
    logic [5:0] wr_addr;
    logic [2:0] len_idx;    // which length byte
    logic      cnt_inc;     // bump message byte count
    logic      cnt_clr;
    logic      rd_en;       // read one schedule word from the buffer
    logic [3:0] rd_word;
    logic      load_wv;     // working vars <= chaining value
    logic      round_en;
    logic [5:0] round;
    logic      chain_add;
    logic      chain_init;
    logic [2:0] out_idx;
  } dp_cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };
    round_k = k[i];
  endfunction

endpackage

### design/sha256_stream_hasher.sv
// top level of the byte-serial sha-256 stream hasher
// sha-256 over a byte stream: one word (byte) is taken per cycle while the
// 64-byte block fills; the 64th byte starts a compression (16 buffer reads,
// 64 rounds on a single round unit, one chaining add) during which no word is
// accepted. on end of message the padding is written into the block buffer one
// byte a cycle up to byte 63, then the final compression runs; when 56 or more
// bytes are pending a second zero/length block is written and one more
// compression follows. the digest leaves as eight 32-bit words, index 0 first,
// last_word set on index 7, after which the hasher is back at the initial
// chaining value with an empty length count.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  dp_cmd_t cmd;

  // controller: handshakes, fill count, padding and round sequencing
  sha256_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .cmd               (cmd)
  );

  // datapath: block buffer, schedule window, round unit, chaining value
  // the data byte goes straight into the buffer write mux
  sha256_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_data_byte),
    .digest_word (out_digest_word)
  );

endmodule

### design/sha256_ram.sv
// generic single-port-write ram with registered read
module sha256_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/sha256_datapath.sv
// block buffer, message schedule, round logic, chaining value and length counter
module sha256_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sha256_pkg::dp_cmd_t cmd,
  input  logic [7:0]         data_byte,
  output logic [31:0]        digest_word
);
  import sha256_pkg::*;

  logic [60:0] msg_cnt_r;
  logic [63:0] bits;
  logic [7:0]  wr_data;
  logic [7:0]  ram_q [4];
  logic [31:0] w_r [16];
  logic [31:0] wv_r [8];
  logic [31:0] cv_r [8];
  logic [31:0] w_cur, w_new, s0, s1, t1, t2, x2, x15;
  logic        rd_d_r;
  logic [3:0]  rd_word_d_r;

  assign bits = {msg_cnt_r, 3'b000};

  always_comb begin
    case (cmd.src)
      BS_DATA: wr_data = data_byte;
      BS_PAD:  wr_data = PAD_BYTE;
      BS_LEN:  wr_data = bits[8*(7-cmd.len_idx) +: 8];
      default: wr_data = 8'h00;
    endcase
  end

  // four byte lanes, one per byte of a big-endian word
  for (genvar g = 0; g < 4; g++) begin : g_lane
    sha256_ram #(.WIDTH(8), .DEPTH(16)) u_ram (
      .clk     (clk),
      .wr_en   (cmd.wr_byte && cmd.wr_addr[1:0] == 2'(g)),
      .wr_addr (cmd.wr_addr[5:2]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_word),
      .rd_data (ram_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_cnt_r <= '0;
      rd_d_r    <= 1'b0;
    end else begin
      rd_d_r <= cmd.rd_en;
      if (cmd.cnt_clr) begin
        msg_cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        msg_cnt_r <= msg_cnt_r + 61'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_word_d_r <= cmd.rd_word;
  end

  // message schedule as a 16-word shift window
  assign x2  = w_r[14];
  assign x15 = w_r[1];
  assign s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
  assign s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
  assign w_new = s1 + w_r[9] + s0 + w_r[0];
  assign w_cur = (cmd.round < 6'd16) ? w_r[cmd.round[3:0]] : w_new;

  always_ff @(posedge clk) begin
    if (rd_d_r) begin
      w_r[rd_word_d_r] <= {ram_q[0], ram_q[1], ram_q[2], ram_q[3]};
    end else if (cmd.round_en && cmd.round >= 6'd16) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end else if (cmd.round_en && cmd.round == 6'd15) begin
      // window is aligned so that w_r[0] is w[i-16] from round 16 on
    end
  end

  assign t1 = wv_r[7] + (rotr(wv_r[4], 6) ^ rotr(wv_r[4], 11) ^ rotr(wv_r[4], 25))
            + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6])) + round_k(cmd.round) + w_cur;
  assign t2 = (rotr(wv_r[0], 2) ^ rotr(wv_r[0], 13) ^ rotr(wv_r[0], 22))
            + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.load_wv) begin
      wv_r <= cv_r;
    end else if (cmd.round_en) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chain_init) begin
      cv_r <= IV;
    end else if (cmd.chain_add) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= cv_r[i] + wv_r[i];
      end
    end
  end

  assign digest_word = cv_r[cmd.out_idx];

endmodule

### design/sha256_ctrl.sv
// controller state machine for byte intake, padding, compression and digest output
module sha256_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_byte_present,
  input  logic               in_end_of_message,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_word_index,
  output logic               out_last_word,
  output sha256_pkg::dp_cmd_t cmd
);
  import sha256_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,  // writes 0x80, zeros and, when it fits, the length into the buffer
    ST_LOAD  = 7'b0000100,  // reads 16 words into the schedule window
    ST_ROUND = 7'b0001000,
    ST_ADD   = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;     // bytes pending in the block
  logic [6:0] pos_r, pos_nxt;       // pad write position / load and round counter
  logic       fin_r, fin_nxt;       // compressing the final block
  logic       pad_r, pad_nxt;       // 0x80 already written
  logic [2:0] oidx_r, oidx_nxt;

  logic       acc;
  logic       full;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign full      = in_byte_present && fill_r == 6'd63;
  assign out_valid = (state_r == ST_OUT);
  assign out_word_index = oidx_r;
  assign out_last_word  = (oidx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    fin_nxt   = fin_r;
    pad_nxt   = pad_r;
    oidx_nxt  = oidx_r;
    cmd       = '0;
    cmd.src   = BS_ZERO;
    cmd.round = pos_r[5:0];
    cmd.rd_word = pos_r[3:0];
    cmd.out_idx = oidx_r;
    cmd.len_idx = pos_r[2:0];
    cmd.wr_addr = fill_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_byte_present) begin
            cmd.wr_byte = 1'b1;
            cmd.src     = BS_DATA;
            cmd.cnt_inc = 1'b1;
            fill_nxt    = fill_r + 6'd1;
          end
          fin_nxt = in_end_of_message;
          pad_nxt = 1'b0;
          if (full) begin
            pos_nxt   = '0;
            state_nxt = ST_LOAD;
          end else if (in_end_of_message) begin
            pos_nxt   = {1'b0, fill_r} + {6'd0, in_byte_present};
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // one byte a cycle from the current position to the end of the block
        cmd.wr_byte = 1'b1;
        cmd.wr_addr = pos_r[5:0];
        if (!pad_r) begin
          cmd.src = BS_PAD;
          pad_nxt = 1'b1;
        end else if (pos_r[5:0] >= LEN_POS && fin_r) begin
          cmd.src = BS_LEN;
        end
        if (!pad_r && pos_r[5:0] >= LEN_POS) begin
          fin_nxt = 1'b0;  // length goes in an extra block
        end
        if (pos_r[5:0] == 6'd63) begin
          if (!pad_r && pos_r[5:0] >= LEN_POS) begin
            fin_nxt = 1'b0;
          end
          pos_nxt   = '0;
          state_nxt = ST_LOAD;
        end else begin
          pos_nxt = pos_r + 7'd1;
        end
      end
      ST_LOAD: begin
        // read issue on counts 0..15, last word lands on count 16
        cmd.rd_en = (pos_r < 7'd16);
        if (pos_r == 7'd16) begin
          cmd.load_wv = 1'b1;
          pos_nxt     = '0;
          state_nxt   = ST_ROUND;
        end else begin
          pos_nxt = pos_r + 7'd1;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (pos_r == 7'd63) begin
          state_nxt = ST_ADD;
        end
        pos_nxt = pos_r + 7'd1;
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        fill_nxt      = '0;
        pos_nxt       = '0;
        if (!pad_r) begin
          state_nxt = fin_r ? ST_PAD : ST_IDLE;
        end else if (fin_r) begin
          oidx_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          // padded block without length: a zero block carrying the length follows
          fin_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // zero fill of the extra block, byte 0 first, length in bytes 56 to 63; 0x80 already placed
        cmd.wr_byte = 1'b1;
        cmd.wr_addr = pos_r[5:0];
        cmd.src     = (pos_r[5:0] >= LEN_POS) ? BS_LEN : BS_ZERO;
        if (pos_r[5:0] == 6'd63) begin
          pos_nxt   = '0;
          state_nxt = ST_LOAD;
        end else begin
          pos_nxt = pos_r + 7'd1;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.chain_init = 1'b1;
            cmd.cnt_clr    = 1'b1;
            fill_nxt       = '0;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
      pad_r   <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= fin_nxt;
      pad_r   <= pad_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

endmodule

### test/testbench.sv
// self-checking testbench for the sha-256 stream hasher
module testbench;
  import sha256_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    bit         drain;   // not a word: hold the sender until all digests are out
  } msg_word_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  localparam int IDLE_LIMIT = 6000;   // cycles without any handshake
  localparam int SETTLE     = 400;    // covers two padding blocks and compressions

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher dut (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // model state
  logic [31:0]  chain [8];
  logic [7:0]   block_buf [64];
  int unsigned  fill;
  logic [60:0]  byte_count;

  msg_word_t    pending_words [$];
  digest_word_t digests_due [$];
  msg_word_t    cur_word;
  int           errors;
  int           msgs_done;
  int           digests_seen;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress(logic [7:0] blk [64]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  // absorb one accepted word; on end of message pad and queue the digest
  function automatic void hash_word(msg_word_t mw);
    logic [7:0]   pad [64];
    logic [63:0]  bits;
    digest_word_t d;
    if (mw.present) begin
      block_buf[fill] = mw.data;
      fill++;
      byte_count++;
      if (fill == 64) begin
        compress(block_buf);
        fill = 0;
      end
    end
    if (!mw.eom) return;
    for (int i = 0; i < 64; i++) pad[i] = (i < fill) ? block_buf[i] : 8'h00;
    pad[fill] = 8'h80;
    if (fill >= 56) begin
      compress(pad);
      for (int i = 0; i < 64; i++) pad[i] = 8'h00;
    end
    bits = {byte_count, 3'b000};
    for (int i = 0; i < 8; i++) pad[56+i] = bits[63-8*i -: 8];
    compress(pad);
    for (int i = 0; i < 8; i++) begin
      d.word  = chain[i];
      d.index = 3'(i);
      d.last  = (i == 7);
      digests_due.push_back(d);
    end
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    fill = 0;
    byte_count = '0;
    msgs_done++;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // queue building helpers
  function automatic void add_word(logic [7:0] b, logic p, logic e);
    msg_word_t mw;
    mw.data = b; mw.present = p; mw.eom = e; mw.drain = 1'b0;
    pending_words.push_back(mw);
  endfunction

  function automatic void add_drain();
    msg_word_t mw;
    mw = '{default: 0};
    mw.drain = 1'b1;
    pending_words.push_back(mw);
  endfunction

  // a message of n bytes; the end mark rides on the last byte or on a bare word
  function automatic int add_message(int n);
    bit bare;
    int cnt;
    bare = (n == 0) || ($urandom_range(0, 2) == 0);
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      add_word(8'($urandom_range(0, 255)), 1'b1, !bare && (i == n - 1));
      cnt++;
      if ($urandom_range(0, 15) == 0) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    if (bare) begin
      add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      cnt++;
    end
    return cnt;
  endfunction

  // driver: bursts of words with random gaps; valid holds until accepted
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid          <= 1'b0;
      in_data_byte      <= 8'h00;
      in_byte_present   <= 1'b0;
      in_end_of_message <= 1'b0;
      burst_left        <= 1;
      gap_left          <= 0;
    end else begin
      if (in_valid && in_ready) hash_word(cur_word);
      if (in_valid && !in_ready) begin
        // holding the current word
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0 && pending_words[0].drain) begin
        in_valid <= 1'b0;
        // wait here until every digest already owed has left the block
        if (digests_due.size() == 0) void'(pending_words.pop_front());
      end else if (pending_words.size() > 0) begin
        cur_word          = pending_words.pop_front();
        in_valid          <= 1'b1;
        in_data_byte      <= cur_word.data;
        in_byte_present   <= cur_word.present;
        in_end_of_message <= cur_word.eom;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold-off right after reset, then changing stall patterns
  int hold_cycles;
  int mode_left;
  int mode;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      hold_cycles <= 600;
      mode_left   <= 0;
      mode        <= 0;
    end else if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if (mode_left == 0) begin
        mode      <= $urandom_range(0, 2);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // monitor: compare each digest word with the oldest one owed
  digest_word_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      digests_seen++;
      if (digests_due.size() == 0) begin
        report("unexpected digest word", out_digest_word, 32'd0);
      end else begin
        want = digests_due.pop_front();
        if (out_digest_word !== want.word) report("digest_word", out_digest_word, want.word);
        if (out_word_index !== want.index)
          report("word_index", 32'(out_word_index), 32'(want.index));
        if (out_last_word !== want.last)
          report("last_word", 32'(out_last_word), 32'(want.last));
      end
    end
  end

  // watchdog on handshake silence while work remains
  int quiet;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (pending_words.size() > 0 || in_valid || digests_due.size() > 0) begin
      quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int rnd_words;
    int rnd_msgs;
    int n;
    errors = 0;
    msgs_done = 0;
    digests_seen = 0;
    fill = 0;
    byte_count = '0;
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty message, ignored word, extreme bytes, bare end mark
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'hff, 1'b0, 1'b0);
    add_word(8'h61, 1'b1, 1'b0);
    add_word(8'h62, 1'b1, 1'b0);
    add_word(8'h63, 1'b1, 1'b1);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'hff, 1'b1, 1'b0);
    add_word(8'haa, 1'b0, 1'b1);
    add_word(8'h55, 1'b1, 1'b1);
    add_word(8'h3c, 1'b0, 1'b1);
    add_drain();

    // random messages, mostly short, some across the padding boundaries
    rnd_words = 0;
    rnd_msgs = 0;
    while (rnd_words < 100) begin
      case ($urandom_range(0, 9))
        0: n = 55;
        1: n = 56 + $urandom_range(0, 8);
        2: n = $urandom_range(0, 130);
        default: n = $urandom_range(0, 12);
      endcase
      // keep the whole run near its word budget
      if (n > 110 - rnd_words) n = 110 - rnd_words;
      rnd_words += add_message(n);
      rnd_msgs++;
      if ($urandom_range(0, 3) == 0) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (rnd_msgs == 4) add_drain();
    end

    wait (pending_words.size() == 0 && !in_valid && digests_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d messages, %0d digest words checked", msgs_done, digests_seen);
    $display("including empty, bare end mark, ignored words and long padding cases");
    if (errors == 0 && digests_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
